// ===== hw/rtl/owst_pkg.sv =====
// ----------------------------------------------------------------------------
// owst_pkg
// Shared types, codes and slot timing for the 1-Wire slot timer.
// ----------------------------------------------------------------------------
package owst_pkg;

    // command codes carried in func
    typedef enum logic [1:0] {
        FUNC_TICK  = 2'd0,
        FUNC_RESET = 2'd1,
        FUNC_WRITE = 2'd2,
        FUNC_READ  = 2'd3
    } func_t;

    // slot phase
    typedef enum logic [1:0] {
        PH_IDLE,
        PH_LOW,
        PH_HIGH
    } phase_t;

    // configuration register indexes
    typedef enum logic [0:0] {
        CFG_TICKS_PER_US   = 1'd0,
        CFG_PRESENCE_DELAY = 1'd1
    } cfg_index_t;

    localparam int unsigned CFG_DATA_W  = 9;
    localparam int unsigned US_COUNT_W  = 10;

    localparam logic [7:0] TICKS_PER_US_RESET   = 8'd16;
    localparam logic [8:0] PRESENCE_DELAY_RESET = 9'd15;

    // microsecond at which a read slot samples, counted from release
    localparam logic [US_COUNT_W-1:0] READ_SAMPLE_US = 10'd9;
    localparam logic [2:0]            LAST_BIT       = 3'd7;

    // one input transaction: one clock tick of bus timing
    typedef struct packed {
        logic [1:0] func;
        logic [7:0] write_value;
        logic       bus_sense;
    } in_item_t;

    // one result transaction
    typedef struct packed {
        logic       drive_low;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_value;
        logic       presence;
        logic       rejected;
    } out_item_t;

    // configuration write
    typedef struct packed {
        logic                  we;
        logic [0:0]            index;
        logic [CFG_DATA_W-1:0] data;
    } cfg_write_t;

    // length of the current slot part in microseconds
    function automatic logic [US_COUNT_W-1:0] part_length(
        input logic [1:0] op,
        input phase_t     ph,
        input logic       bit_one
    );
        logic [US_COUNT_W-1:0] len;
        begin
            if (op == FUNC_RESET)
            begin
                len = (ph == PH_LOW) ? 10'd480 : 10'd495;
            end
            else if (op == FUNC_WRITE)
            begin
                if (ph == PH_LOW)
                begin
                    len = bit_one ? 10'd6 : 10'd60;
                end
                else
                begin
                    len = bit_one ? 10'd64 : 10'd10;
                end
            end
            else
            begin
                len = (ph == PH_LOW) ? 10'd6 : 10'd64;
            end
            return len;
        end
    endfunction

endpackage

// ===== hw/rtl/owst_in_if.sv =====
// ----------------------------------------------------------------------------
// owst_in_if
// Valid/ready channel carrying one tick transaction into the slot timer.
// ----------------------------------------------------------------------------
interface owst_in_if;
    logic               valid;
    logic               ready;
    owst_pkg::in_item_t item;

    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

// ===== hw/rtl/owst_out_if.sv =====
// ----------------------------------------------------------------------------
// owst_out_if
// Valid/ready channel carrying one result transaction out of the slot timer.
// ----------------------------------------------------------------------------
interface owst_out_if;
    logic                valid;
    logic                ready;
    owst_pkg::out_item_t item;

    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

// ===== hw/rtl/one_wire_master_slot_timer.sv =====
// ----------------------------------------------------------------------------
// one_wire_master_slot_timer
// 1-Wire bus master: reset, byte write and byte read slots timed in
// microseconds through a programmable prescaler, one tick per transaction.
//
//   channel  dir  payload                                          handshake
//   cmd      in   func, write_value, bus_sense                     valid/ready
//   res      out  drive_low, busy_res, done_res, read_value,       valid/ready
//                 presence, rejected
//   cfg_*    in   cfg_index, cfg_data                              cfg_we only
//
// One tick transaction per clock while the result side keeps up; each passes the
// input register, the slot update and the result register before its result shows.
// Reset clears slot state and loads 16 ticks/us and a 15us presence sample.
// A stalled result only holds the pipe once both registers are full; the
// input side keeps taking transactions while the result register drains.
// ----------------------------------------------------------------------------
module one_wire_master_slot_timer (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [0:0]                          cfg_index,
    input  logic [owst_pkg::CFG_DATA_W-1:0]     cfg_data,
    owst_in_if.sink                             cmd,
    owst_out_if.source                          res
);
    import owst_pkg::*;

    logic       item_valid;
    in_item_t   item;
    out_item_t  result;
    logic       can_load;
    logic       advance;
    cfg_write_t cfg;

    assign advance   = item_valid && can_load;
    assign cfg.we    = cfg_we;
    assign cfg.index = cfg_index;
    assign cfg.data  = cfg_data;

    // input register
    owst_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .take       (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    // slot timing engine
    owst_slot_engine u_engine (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .step   (advance),
        .item   (item),
        .result (result)
    );

    // result register
    owst_out_stage u_out_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (advance),
        .item     (result),
        .can_load (can_load),
        .res      (res)
    );
endmodule

// ===== hw/rtl/owst_in_stage.sv =====
// ----------------------------------------------------------------------------
// owst_in_stage
// Input register: holds one tick transaction until the engine consumes it.
// ----------------------------------------------------------------------------
module owst_in_stage (
    input  logic               clk,
    input  logic               rst_n,
    owst_in_if.sink            cmd,
    input  logic               take,
    output logic               item_valid,
    output owst_pkg::in_item_t item
);
    import owst_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;

    // accept while empty or while the held transaction moves on
    assign cmd.ready  = !valid_reg || take;
    assign valid_next = (cmd.valid && cmd.ready) ? 1'b1 : (take ? 1'b0 : valid_reg);

    // occupancy flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload capture
    always_ff @(posedge clk)
    begin
        if (cmd.valid && cmd.ready)
        begin
            item_reg <= cmd.item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;
endmodule

// ===== hw/rtl/owst_slot_engine.sv =====
// ----------------------------------------------------------------------------
// owst_slot_engine
// Slot state, prescaler and configuration; one tick of bus timing per step.
// ----------------------------------------------------------------------------
module owst_slot_engine (
    input  logic                 clk,
    input  logic                 rst_n,
    input  owst_pkg::cfg_write_t cfg,
    input  logic                 step,
    input  owst_pkg::in_item_t   item,
    output owst_pkg::out_item_t  result
);
    import owst_pkg::*;

    logic [7:0]            ticks_per_us_reg;
    logic [8:0]            presence_delay_reg;

    phase_t                phase_reg,  phase_next;
    logic [1:0]            op_reg,     op_next;
    logic [7:0]            div_reg,    div_next;
    logic [US_COUNT_W-1:0] us_reg,     us_next;
    logic [2:0]            bit_reg,    bit_next;
    logic [7:0]            shift_reg,  shift_next;
    logic                  pres_reg,   pres_next;
    logic [7:0]            last_reg,   last_next;

    logic [7:0]            tpm;
    logic [8:0]            div_inc;
    logic [US_COUNT_W-1:0] us_inc;
    logic                  drive;
    logic                  done;
    logic                  rej;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ticks_per_us_reg   <= TICKS_PER_US_RESET;
            presence_delay_reg <= PRESENCE_DELAY_RESET;
        end
        else if (cfg.we)
        begin
            unique case (cfg.index)
                CFG_TICKS_PER_US:   ticks_per_us_reg   <= cfg.data[7:0];
                CFG_PRESENCE_DELAY: presence_delay_reg <= cfg.data;
                default:            ;
            endcase
        end
    end

    assign tpm = (ticks_per_us_reg == 8'd0) ? 8'd1 : ticks_per_us_reg;

    // next state for one tick
    always_comb
    begin
        phase_next = phase_reg;
        op_next    = op_reg;
        div_next   = div_reg;
        us_next    = us_reg;
        bit_next   = bit_reg;
        shift_next = shift_reg;
        pres_next  = pres_reg;
        last_next  = last_reg;
        drive      = 1'b0;
        done       = 1'b0;
        rej        = 1'b0;
        div_inc    = '0;
        us_inc     = '0;

        // command start or rejection
        if (item.func != FUNC_TICK)
        begin
            if (phase_reg == PH_IDLE)
            begin
                op_next    = item.func;
                phase_next = PH_LOW;
                div_next   = '0;
                us_next    = '0;
                bit_next   = '0;
                shift_next = (item.func == FUNC_WRITE) ? item.write_value : 8'd0;
                if (item.func == FUNC_RESET)
                begin
                    pres_next = 1'b0;
                end
            end
            else
            begin
                rej = 1'b1;
            end
        end

        if (phase_next != PH_IDLE)
        begin
            drive = (phase_next == PH_LOW);

            // sampling on the first tick of the microsecond
            if (phase_next == PH_HIGH && div_next == 8'd0)
            begin
                if (op_next == FUNC_RESET && us_next == {1'b0, presence_delay_reg})
                begin
                    pres_next = !item.bus_sense;
                end
                else if (op_next == FUNC_READ && us_next == READ_SAMPLE_US)
                begin
                    shift_next = {item.bus_sense, shift_next[7:1]};
                end
            end

            // prescaler and microsecond counter
            div_inc = {1'b0, div_next} + 9'd1;
            if (div_inc >= {1'b0, tpm})
            begin
                div_next = '0;
                us_inc   = us_next + 10'd1;
                if (us_inc >= part_length(op_next, phase_next, shift_next[0]))
                begin
                    us_next = '0;
                    if (phase_next == PH_LOW)
                    begin
                        phase_next = PH_HIGH;
                    end
                    else if (op_next == FUNC_RESET)
                    begin
                        phase_next = PH_IDLE;
                        done       = 1'b1;
                    end
                    else
                    begin
                        if (op_next == FUNC_WRITE)
                        begin
                            shift_next = {1'b0, shift_next[7:1]};
                        end
                        if (bit_next >= LAST_BIT)
                        begin
                            if (op_next == FUNC_READ)
                            begin
                                last_next = shift_next;
                            end
                            bit_next   = '0;
                            phase_next = PH_IDLE;
                            done       = 1'b1;
                        end
                        else
                        begin
                            bit_next   = bit_next + 3'd1;
                            phase_next = PH_LOW;
                        end
                    end
                end
                else
                begin
                    us_next = us_inc;
                end
            end
            else
            begin
                div_next = div_inc[7:0];
            end
        end
    end

    // slot state registers, advanced once per consumed tick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            op_reg    <= '0;
            div_reg   <= '0;
            us_reg    <= '0;
            bit_reg   <= '0;
            shift_reg <= '0;
            pres_reg  <= 1'b0;
            last_reg  <= '0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            op_reg    <= op_next;
            div_reg   <= div_next;
            us_reg    <= us_next;
            bit_reg   <= bit_next;
            shift_reg <= shift_next;
            pres_reg  <= pres_next;
            last_reg  <= last_next;
        end
    end

    // result of this tick
    always_comb
    begin
        result.drive_low  = drive;
        result.busy_res   = (phase_next != PH_IDLE);
        result.done_res   = done;
        result.read_value = last_next;
        result.presence   = pres_next;
        result.rejected   = rej;
    end
endmodule

// ===== hw/rtl/owst_out_stage.sv =====
// ----------------------------------------------------------------------------
// owst_out_stage
// Result register: holds one result transaction until the sink takes it.
// ----------------------------------------------------------------------------
module owst_out_stage (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  owst_pkg::out_item_t item,
    output logic                can_load,
    owst_out_if.source          res
);
    import owst_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    out_item_t item_reg;

    // free when empty or when the held result leaves this cycle
    assign can_load   = !valid_reg || res.ready;
    assign valid_next = load ? 1'b1 : (res.ready ? 1'b0 : valid_reg);

    // occupancy flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload capture
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= item;
        end
    end

    assign res.valid = valid_reg;
    assign res.item  = item_reg;
endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives the 1-Wire slot timer one tick transaction at a time and checks every
// result transaction against a cycle-exact model of the slot timing or a typed-in
// result. A short table of directed ticks comes first. Randomised phases follow at
// several prescaler and presence-sample settings, with random idling on both
// channels and one long result stall that backs the pipe up.
// ----------------------------------------------------------------------------
module testbench;
    import owst_pkg::*;

    localparam int HOLD_CYCLES = 300;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [0:0]            cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    owst_in_if  cmd_ch ();
    owst_out_if res_ch ();

    one_wire_master_slot_timer i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd_ch),
        .res       (res_ch)
    );

    // directed tick with an optional typed-in result
    typedef struct {
        in_item_t  stim;
        bit        typed;
        out_item_t want;
    } tick_row_t;

    tick_row_t directed_rows [$];
    out_item_t expected_results [$];

    // typed result travelling with the transaction on offer
    bit        row_typed = 1'b0;
    out_item_t row_want = '0;

    int fail_count = 0;
    bit no_idle = 1'b0;
    bit hold_request = 1'b0;
    int send_quiet = 0;

    // bus master state as the block should hold it
    logic [7:0]            ticks_per_us = TICKS_PER_US_RESET;
    logic [8:0]            presence_delay = PRESENCE_DELAY_RESET;
    phase_t                slot_phase = PH_IDLE;
    func_t                 slot_op = FUNC_TICK;
    logic [7:0]            tick_div = '0;
    logic [US_COUNT_W-1:0] us_count = '0;
    logic [2:0]            bit_pos = '0;
    logic [7:0]            shift_reg = '0;
    logic                  presence_seen = 1'b0;
    logic [7:0]            last_byte = '0;

    always #4 clk = ~clk;

    // advance the bus master by one tick and return what it shows
    function automatic out_item_t tick_bus_master(in_item_t t);
        out_item_t             r;
        logic [7:0]            rate;
        logic [US_COUNT_W-1:0] part;
        logic                  drive;
        logic                  done;
        logic                  rej;
        begin
            rate  = (ticks_per_us == 8'd0) ? 8'd1 : ticks_per_us;
            drive = 1'b0;
            done  = 1'b0;
            rej   = 1'b0;

            // command start or rejection
            if (t.func != FUNC_TICK)
            begin
                if (slot_phase == PH_IDLE)
                begin
                    slot_op    = func_t'(t.func);
                    slot_phase = PH_LOW;
                    tick_div   = '0;
                    us_count   = '0;
                    bit_pos    = '0;
                    shift_reg  = (t.func == FUNC_WRITE) ? t.write_value : 8'd0;
                    if (t.func == FUNC_RESET)
                    begin
                        presence_seen = 1'b0;
                    end
                end
                else
                begin
                    rej = 1'b1;
                end
            end

            if (slot_phase != PH_IDLE)
            begin
                drive = (slot_phase == PH_LOW);

                // line sampling on the first tick of a microsecond
                if (slot_phase == PH_HIGH && tick_div == 8'd0)
                begin
                    if (slot_op == FUNC_RESET && us_count == presence_delay)
                    begin
                        presence_seen = ~t.bus_sense;
                    end
                    else if (slot_op == FUNC_READ && us_count == READ_SAMPLE_US)
                    begin
                        shift_reg = {t.bus_sense, shift_reg[7:1]};
                    end
                end

                // prescaler, microsecond count and slot sequencing
                tick_div = tick_div + 8'd1;
                if (tick_div >= rate)
                begin
                    tick_div = '0;
                    us_count = us_count + 1'b1;
                    if (slot_op == FUNC_RESET)
                    begin
                        part = (slot_phase == PH_LOW) ? 10'd480 : 10'd495;
                    end
                    else if (slot_op == FUNC_WRITE)
                    begin
                        part = (slot_phase == PH_LOW) ? (shift_reg[0] ? 10'd6 : 10'd60)
                                                      : (shift_reg[0] ? 10'd64 : 10'd10);
                    end
                    else
                    begin
                        part = (slot_phase == PH_LOW) ? 10'd6 : 10'd64;
                    end

                    if (us_count >= part)
                    begin
                        us_count = '0;
                        if (slot_phase == PH_LOW)
                        begin
                            slot_phase = PH_HIGH;
                        end
                        else if (slot_op == FUNC_RESET)
                        begin
                            slot_phase = PH_IDLE;
                            done       = 1'b1;
                        end
                        else
                        begin
                            if (slot_op == FUNC_WRITE)
                            begin
                                shift_reg = shift_reg >> 1;
                            end
                            if (bit_pos == LAST_BIT)
                            begin
                                if (slot_op == FUNC_READ)
                                begin
                                    last_byte = shift_reg;
                                end
                                bit_pos    = '0;
                                slot_phase = PH_IDLE;
                                done       = 1'b1;
                            end
                            else
                            begin
                                bit_pos    = bit_pos + 3'd1;
                                slot_phase = PH_LOW;
                            end
                        end
                    end
                end
            end

            r.drive_low  = drive;
            r.busy_res   = (slot_phase != PH_IDLE);
            r.done_res   = done;
            r.read_value = last_byte;
            r.presence   = presence_seen;
            r.rejected   = rej;
            return r;
        end
    endfunction

    // random tick: commands on half the idle ticks, rare rejected ones when busy
    function automatic in_item_t random_tick();
        in_item_t t;
        begin
            t.write_value = 8'($urandom_range(0, 255));
            t.bus_sense   = 1'($urandom_range(0, 1));
            t.func        = FUNC_TICK;
            if (slot_phase == PH_IDLE ? ($urandom_range(0, 1) == 0)
                                      : ($urandom_range(0, 31) == 0))
            begin
                t.func = 2'($urandom_range(1, 3));
            end
            return t;
        end
    endfunction

    function automatic void add_row(func_t f, logic [7:0] wv, logic sense, bit typed,
                                    logic drive, logic busy, logic rej);
        tick_row_t row;
        begin
            row.stim.func        = f;
            row.stim.write_value = wv;
            row.stim.bus_sense   = sense;
            row.typed            = typed;
            row.want             = '0;
            row.want.drive_low   = drive;
            row.want.busy_res    = busy;
            row.want.rejected    = rej;
            directed_rows.push_back(row);
        end
    endfunction

    // offer one tick transaction, with an occasional gap before it
    task automatic offer_tick(in_item_t stim, bit draw, bit typed, out_item_t want);
        int gap;
        begin
            gap = 0;
            if (!no_idle)
            begin
                if (send_quiet > 0)
                begin
                    send_quiet--;
                end
                else if ($urandom_range(0, 63) == 0)
                begin
                    send_quiet = $urandom_range(100, 400);
                end
                else if ($urandom_range(0, 11) == 0)
                begin
                    gap = $urandom_range(1, 16);
                end
            end
            @(negedge clk);
            if (gap != 0)
            begin
                cmd_ch.valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            if (draw)
            begin
                stim = random_tick();
            end
            cmd_ch.valid <= 1'b1;
            cmd_ch.item  <= stim;
            row_typed    <= typed;
            row_want     <= want;
            do
                @(posedge clk);
            while (!cmd_ch.ready);
        end
    endtask

    // stop offering and wait for every outstanding result
    task automatic drain();
        @(negedge clk);
        cmd_ch.valid <= 1'b0;
        while (expected_results.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic write_register(cfg_index_t idx, logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        if (idx == CFG_TICKS_PER_US)
        begin
            ticks_per_us = value[7:0];
        end
        else
        begin
            presence_delay = value;
        end
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // one random phase at a given prescaler and presence sample point
    task automatic run_phase(logic [7:0] rate, logic [8:0] delay, int count, bit hold);
        begin
            drain();
            write_register(CFG_TICKS_PER_US, {1'b0, rate});
            write_register(CFG_PRESENCE_DELAY, delay);
            hold_request = hold;
            repeat (count) offer_tick('0, 1'b1, 1'b0, '0);
        end
    endtask

    // result checking, then prediction of the newly accepted tick
    always @(posedge clk)
    begin : scoreboard
        out_item_t want;
        out_item_t got;
        out_item_t predicted;
        if (rst_n)
        begin
            if (res_ch.valid && res_ch.ready)
            begin
                got = res_ch.item;
                if (expected_results.size() == 0)
                begin
                    $error("result transaction with nothing expected");
                    fail_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got.drive_low !== want.drive_low)
                    begin
                        $error("drive_low: expected %0d, got %0d", want.drive_low, got.drive_low);
                        fail_count++;
                    end
                    if (got.busy_res !== want.busy_res)
                    begin
                        $error("busy_res: expected %0d, got %0d", want.busy_res, got.busy_res);
                        fail_count++;
                    end
                    if (got.done_res !== want.done_res)
                    begin
                        $error("done_res: expected %0d, got %0d", want.done_res, got.done_res);
                        fail_count++;
                    end
                    if (got.read_value !== want.read_value)
                    begin
                        $error("read_value: expected %0h, got %0h", want.read_value,
                               got.read_value);
                        fail_count++;
                    end
                    if (got.presence !== want.presence)
                    begin
                        $error("presence: expected %0d, got %0d", want.presence, got.presence);
                        fail_count++;
                    end
                    if (got.rejected !== want.rejected)
                    begin
                        $error("rejected: expected %0d, got %0d", want.rejected, got.rejected);
                        fail_count++;
                    end
                end
            end

            if (cmd_ch.valid && cmd_ch.ready)
            begin
                predicted = tick_bus_master(cmd_ch.item);
                expected_results.push_back(row_typed ? row_want : predicted);
            end
        end
    end

    // result side: random stalls, quiet stretches and one long hold-off
    initial
    begin : result_sink
        int stall;
        int quiet;
        quiet = 0;
        res_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                res_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_request = 1'b0;
                res_ch.ready <= 1'b1;
            end
            else if (no_idle || quiet > 0)
            begin
                if (quiet > 0)
                begin
                    quiet--;
                end
                res_ch.ready <= 1'b1;
            end
            else if ($urandom_range(0, 63) == 0)
            begin
                quiet = $urandom_range(100, 400);
                res_ch.ready <= 1'b1;
            end
            else if ($urandom_range(0, 9) == 0)
            begin
                stall = $urandom_range(1, 16);
                res_ch.ready <= 1'b0;
                repeat (stall) @(negedge clk);
                res_ch.ready <= 1'b1;
            end
            else
            begin
                res_ch.ready <= 1'b1;
            end
        end
    end

    initial
    begin : main_sequence
        cmd_ch.valid = 1'b0;
        cmd_ch.item  = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // idle after reset, a write start, commands while busy, then untyped ticks and commands
        add_row(FUNC_TICK,  8'h00, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0);
        add_row(FUNC_TICK,  8'hFF, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0);
        add_row(FUNC_WRITE, 8'hA5, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0);
        add_row(FUNC_READ,  8'hFF, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1);
        add_row(FUNC_RESET, 8'h00, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1);
        add_row(FUNC_WRITE, 8'h00, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1);
        add_row(FUNC_TICK,  8'h5A, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        add_row(FUNC_TICK,  8'hC3, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
        add_row(FUNC_READ,  8'h3C, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
        add_row(FUNC_TICK,  8'hFF, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        add_row(FUNC_TICK,  8'h00, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
        add_row(FUNC_RESET, 8'h81, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        add_row(FUNC_TICK,  8'h7E, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
        add_row(FUNC_TICK,  8'h18, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        foreach (directed_rows[i])
        begin
            offer_tick(directed_rows[i].stim, 1'b0, directed_rows[i].typed,
                       directed_rows[i].want);
        end

        // first phase retimes the write still in flight and holds results off
        run_phase(8'd1, 9'd15, 300, 1'b1);
        // zero prescaler and a sample on the first released microsecond
        run_phase(8'd0, 9'd0, 250, 1'b0);
        run_phase(8'd1, 9'd480, 200, 1'b0);
        // sample point beyond the released part
        run_phase(8'd2, 9'd511, 150, 1'b0);
        run_phase(8'd255, 9'd1, 80, 1'b0);
        run_phase(8'd1, 9'd494, 200, 1'b0);
        no_idle = 1'b1;
        run_phase(8'd3, 9'd495, 206, 1'b0);

        drain();
        repeat (8) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial
    begin : watchdog
        #4_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
